@@ rtl/core/vtwm_pkg.sv @@
// Shared types, widths, field positions and register codes of the
// vibration, tilt and climate window monitor. No dependencies.
`timescale 1ns / 1ps

package vtwm_pkg;

  // Accelerometer sample width and the widths that follow from it
  localparam int ACCEL_WIDTH = 16;
  localparam int SQ_W        = 2 * ACCEL_WIDTH;
  localparam int MUL_W       = (SQ_W > 32) ? SQ_W : 32;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int MAG_W       = (ACCEL_WIDTH > 16) ? ACCEL_WIDTH : 16;
  localparam int ROOT_CNT_W  = (ACCEL_WIDTH > 1) ? $clog2(ACCEL_WIDTH) : 1;

  // Tangent register is Q0.16, so its square carries a 2^32 scale
  localparam int TAN_W   = 16;
  localparam int TAN2_W  = 2 * TAN_W;

  // Result arithmetic
  localparam int VIB_W      = 16;
  localparam int PGA_W      = 23;
  localparam int SI_FAC_W   = 16;
  localparam int SI_SHIFT   = 16;
  localparam int SI_FULL_W  = PGA_W + SI_FAC_W - SI_SHIFT;
  localparam int SI_W       = 19;
  localparam int PGA_SCALE  = 100;
  localparam int TEMP_W     = 11;
  localparam int PEAK_W     = 10;
  localparam int SEC_W      = 16;

  // Input word layout, lowest bit first
  localparam int X_LSB      = 0;
  localparam int Y_LSB      = ACCEL_WIDTH;
  localparam int Z_LSB      = 2 * ACCEL_WIDTH;
  localparam int T_LSB      = 3 * ACCEL_WIDTH;
  localparam int TOK_BIT    = T_LSB + TEMP_W;
  localparam int H_LSB      = TOK_BIT + 1;
  localparam int HOK_BIT    = H_LSB + PEAK_W;
  localparam int IN_W       = HOK_BIT + 1;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

  // Result word layout, lowest bit first
  localparam int OUT_W      = PGA_W + SI_W + 2 + 2 * PEAK_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Request kinds carried in tuser
  localparam logic [1:0] REQ_ACCEL   = 2'd0;
  localparam logic [1:0] REQ_CLIMATE = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_TAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SI_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAKE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd5;

  // Register reset values
  localparam logic [15:0]     GRAVITY_RST  = 16'd2511;
  localparam logic [15:0]     TILT_TAN_RST = 16'd23853;
  localparam logic [15:0]     SI_GAIN_RST  = 16'd4588;
  localparam logic [SI_W-1:0] QUAKE_RST    = 19'd1280;
  localparam logic [SI_W-1:0] COLLAPSE_RST = 19'd10240;
  localparam logic [15:0]     WINDOW_RST   = 16'd60;

  // Status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

@@ rtl/core/vibration_tilt_window_monitor.sv @@
// Top level of the vibration, tilt and climate window monitor: sequencer,
// window state, configuration and output register. Uses vtwm_pkg,
// vtwm_mul and vtwm_isqrt.
`timescale 1ns / 1ps

// An accelerometer word runs four squaring passes through the shared 32x32
// multiplier, then the 16-step square root, which runs beside the two
// tangent products; no new word is accepted until it is through. A climate
// word and a tick that does not close the window are handled without
// leaving the idle state. A tick that closes the window runs two multiplier
// passes and then waits until the previous result has been taken. A climate
// word skips failed readings; request kind 3 is accepted and ignored. The
// result register lets new words be accepted while a result waits
// downstream. Configuration writes take effect at once and belong in idle
// periods.

module vibration_tilt_window_monitor
  import vtwm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata fields from bit 0: accel_x, accel_y, accel_z, temperature,
  // temperature_ok, humidity, humidity_ok, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // tuser fields from bit 0: req_type
  input  logic [1:0]             s_tuser,
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata fields from bit 0: pga_value, intensity_value, quake_flag,
  // collapse_flag, peak_temperature, peak_humidity
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_MZ   = 4'd3;
  localparam logic [3:0] S_MT   = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_P1   = 4'd6;
  localparam logic [3:0] S_P2   = 4'd7;
  localparam logic [3:0] S_VIB  = 4'd8;
  localparam logic [3:0] S_PGA  = 4'd9;
  localparam logic [3:0] S_SI   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state;

  // Configuration registers
  logic [15:0]     gravity_q8;
  logic [15:0]     tilt_tangent_q16;
  logic [15:0]     si_per_pga_q16;
  logic [SI_W-1:0] quake_threshold;
  logic [SI_W-1:0] collapse_threshold;
  logic [15:0]     window_seconds;

  // Window state
  logic [VIB_W-1:0]  peak_vibration;
  logic              tilted_seen;
  logic [PEAK_W-1:0] peak_temp_store;
  logic [PEAK_W-1:0] peak_hum_store;
  logic [SEC_W-1:0]  seconds_elapsed;
  logic [SEC_W-1:0]  seconds_next;

  // Working registers of one sample
  logic [ACCEL_WIDTH-1:0] ax, ay, az;
  logic                   yz_zero;
  logic                   z_pos;
  logic [SQ_W-1:0]        x2, y2, z2;
  logic [TAN2_W-1:0]      t2;
  logic [PGA_W-1:0]       pga;

  // Result register
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   out_load;

  // Shared units
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic                   sqrt_start;
  logic [SQ_W-1:0]        sqrt_rad;
  sqrt_stat_t             sqrt_stat;
  logic [ACCEL_WIDTH-1:0] sqrt_root;

  // Input fields
  logic [1:0]             in_kind;
  logic [ACCEL_WIDTH-1:0] in_x, in_y, in_z;
  logic [TEMP_W-1:0]      in_temp;
  logic                   in_temp_ok;
  logic [PEAK_W-1:0]      in_hum;
  logic                   in_hum_ok;
  logic                   in_accept;

  // Derived values
  logic [PROD_W-1:0]      pitch_lhs, roll_lhs;
  logic                   roll_ok;
  logic [MAG_W-1:0]       mag_e, grav_e, vib_diff;
  logic [VIB_W-1:0]       vib;
  logic [SI_FULL_W-1:0]   si_full;
  logic [SI_W-1:0]        si_sat;
  logic                   quake_flag, collapse_flag;

  assign in_kind    = s_tuser;
  assign in_x       = s_tdata[X_LSB +: ACCEL_WIDTH];
  assign in_y       = s_tdata[Y_LSB +: ACCEL_WIDTH];
  assign in_z       = s_tdata[Z_LSB +: ACCEL_WIDTH];
  assign in_temp    = s_tdata[T_LSB +: TEMP_W];
  assign in_temp_ok = s_tdata[TOK_BIT];
  assign in_hum     = s_tdata[H_LSB +: PEAK_W];
  assign in_hum_ok  = s_tdata[HOK_BIT];

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // Saturating tick count
  assign seconds_next = (seconds_elapsed != {SEC_W{1'b1}}) ? seconds_elapsed + 1'b1
                                                           : seconds_elapsed;

  // Tilt comparisons against the squared tangent products
  assign pitch_lhs = PROD_W'({x2, 32'b0});
  assign roll_lhs  = PROD_W'({y2, 32'b0});
  assign roll_ok   = yz_zero || (z_pos && !(roll_lhs > mul_p));

  // Vibration value from the magnitude, saturated to the vibration width
  assign mag_e    = MAG_W'(sqrt_root);
  assign grav_e   = MAG_W'(gravity_q8);
  assign vib_diff = (mag_e >= grav_e) ? mag_e - grav_e : grav_e - mag_e;
  assign vib      = (vib_diff > MAG_W'({VIB_W{1'b1}})) ? {VIB_W{1'b1}}
                                                      : vib_diff[VIB_W-1:0];

  // Intensity from the second multiplier pass of a window close
  assign si_full       = mul_p[PGA_W+SI_FAC_W-1:SI_SHIFT];
  assign si_sat        = (|si_full[SI_FULL_W-1:SI_W]) ? {SI_W{1'b1}}
                                                      : si_full[SI_W-1:0];
  assign quake_flag    = (si_full > SI_FULL_W'(quake_threshold));
  assign collapse_flag = tilted_seen || (si_full > SI_FULL_W'(collapse_threshold));
  assign out_load      = (state == S_OUT) && (!out_valid || m_tready);

  // Multiplier operand selection per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MX: begin
        mul_a = MUL_W'(ax);
        mul_b = MUL_W'(ax);
      end
      S_MY: begin
        mul_a = MUL_W'(ay);
        mul_b = MUL_W'(ay);
      end
      S_MZ: begin
        mul_a = MUL_W'(az);
        mul_b = MUL_W'(az);
      end
      S_MT: begin
        mul_a = MUL_W'(tilt_tangent_q16);
        mul_b = MUL_W'(tilt_tangent_q16);
      end
      S_SQ: begin
        mul_a = MUL_W'(mul_p[TAN2_W-1:0]);
        mul_b = MUL_W'(y2 + z2);
      end
      S_P1: begin
        mul_a = MUL_W'(t2);
        mul_b = MUL_W'(z2);
      end
      S_PGA: begin
        mul_a = MUL_W'(peak_vibration);
        mul_b = MUL_W'(PGA_SCALE);
      end
      S_SI, S_OUT: begin
        mul_a = MUL_W'(state == S_SI ? mul_p[PGA_W-1:0] : pga);
        mul_b = MUL_W'(si_per_pga_q16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sqrt_start = (state == S_SQ);
  assign sqrt_rad   = x2 + y2 + z2;

  vtwm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  vtwm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .stat     (sqrt_stat),
    .root     (sqrt_root)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_q8         <= GRAVITY_RST;
      tilt_tangent_q16   <= TILT_TAN_RST;
      si_per_pga_q16     <= SI_GAIN_RST;
      quake_threshold    <= QUAKE_RST;
      collapse_threshold <= COLLAPSE_RST;
      window_seconds     <= WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY:  gravity_q8         <= cfg_data[15:0];
        CFG_TILT_TAN: tilt_tangent_q16   <= cfg_data[15:0];
        CFG_SI_GAIN:  si_per_pga_q16     <= cfg_data[15:0];
        CFG_QUAKE:    quake_threshold    <= cfg_data;
        CFG_COLLAPSE: collapse_threshold <= cfg_data;
        CFG_WINDOW:   window_seconds     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      peak_vibration  <= '0;
      tilted_seen     <= 1'b0;
      peak_temp_store <= '0;
      peak_hum_store  <= '0;
      seconds_elapsed <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            unique case (in_kind)
              REQ_ACCEL: state <= S_MX;
              REQ_CLIMATE: begin
                if (in_temp_ok && !in_temp[TEMP_W-1] &&
                    (in_temp[PEAK_W-1:0] > peak_temp_store)) begin
                  peak_temp_store <= in_temp[PEAK_W-1:0];
                end
                if (in_hum_ok && (in_hum > peak_hum_store)) begin
                  peak_hum_store <= in_hum;
                end
              end
              REQ_TICK: begin
                seconds_elapsed <= seconds_next;
                if (seconds_next >= window_seconds) begin
                  state <= S_PGA;
                end
              end
              default: ;
            endcase
          end
        end
        S_MX:  state <= S_MY;
        S_MY:  state <= S_MZ;
        S_MZ:  state <= S_MT;
        S_MT:  state <= S_SQ;
        S_SQ:  state <= S_P1;
        S_P1: begin
          if (pitch_lhs > mul_p) begin
            tilted_seen <= 1'b1;
          end
          state <= S_P2;
        end
        S_P2: begin
          if (!roll_ok) begin
            tilted_seen <= 1'b1;
          end
          state <= S_VIB;
        end
        S_VIB: begin
          if (sqrt_stat.done) begin
            if (vib > peak_vibration) begin
              peak_vibration <= vib;
            end
            state <= S_IDLE;
          end
        end
        S_PGA: state <= S_SI;
        S_SI:  state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            peak_vibration  <= '0;
            tilted_seen     <= 1'b0;
            peak_temp_store <= '0;
            peak_hum_store  <= '0;
            seconds_elapsed <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture sample magnitudes and the products of each step
  always_ff @(posedge clk) begin
    if (in_accept && (in_kind == REQ_ACCEL)) begin
      ax      <= in_x[ACCEL_WIDTH-1] ? ~in_x + 1'b1 : in_x;
      ay      <= in_y[ACCEL_WIDTH-1] ? ~in_y + 1'b1 : in_y;
      az      <= in_z[ACCEL_WIDTH-1] ? ~in_z + 1'b1 : in_z;
      yz_zero <= (in_y == '0) && (in_z == '0);
      z_pos   <= !in_z[ACCEL_WIDTH-1] && (in_z != '0);
    end
    if (state == S_MY) x2 <= mul_p[SQ_W-1:0];
    if (state == S_MZ) y2 <= mul_p[SQ_W-1:0];
    if (state == S_MT) z2 <= mul_p[SQ_W-1:0];
    if (state == S_SQ) t2 <= mul_p[TAN2_W-1:0];
    if (state == S_SI) pga <= mul_p[PGA_W-1:0];
  end

  // Result register: load on window close, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= OUT_TDATA_W'({peak_hum_store, peak_temp_store, collapse_flag,
                                quake_flag, si_sat, pga});
    end
  end

  // Window close clears the state and presents a result
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (seconds_elapsed == '0) && (peak_vibration == '0) &&
                 !tilted_seen && m_tvalid)
    else $error("window close did not clear state or present a result");

  // The root only finishes while the sequencer waits for it
  a_sqrt_done_state: assert property (@(posedge clk) disable iff (rst)
    sqrt_stat.done |-> (state == S_VIB))
    else $error("square root finished outside its wait step");

  // A quake flag implies the reported intensity reaches the threshold
  a_quake_consistent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_data[PGA_W+SI_W]) |->
      (out_data[PGA_W +: SI_W] >= quake_threshold))
    else $error("quake flag without intensity above threshold");

endmodule

@@ rtl/core/vtwm_mul.sv @@
// Shared multiplier of the window monitor: one registered product per cycle.
// Depends on vtwm_pkg for operand widths.
`timescale 1ns / 1ps

module vtwm_mul
  import vtwm_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  // Register the product of the current operands
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ rtl/core/vtwm_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on vtwm_pkg for widths and the status struct.
`timescale 1ns / 1ps

module vtwm_isqrt
  import vtwm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SQ_W-1:0]        radicand,
  output sqrt_stat_t             stat,
  output logic [ACCEL_WIDTH-1:0] root
);

  // The remainder entering any step stays below 2^ACCEL_WIDTH; only the
  // remainder left by the last step can be wider, and it is never read
  logic [SQ_W-1:0]        rad;
  logic [ACCEL_WIDTH-1:0] rem;
  logic [ROOT_CNT_W-1:0]  cnt;
  logic [ACCEL_WIDTH+1:0] shifted;
  logic [ACCEL_WIDTH+1:0] trial;
  logic                   ge;

  // Bring down two radicand bits and try the next root bit
  assign shifted = {rem, rad[SQ_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign ge      = (shifted >= trial);

  // Control: busy while stepping, done pulses after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ROOT_CNT_W'(ACCEL_WIDTH - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, root and radicand shift
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (stat.busy) begin
      rad  <= {rad[SQ_W-3:0], 2'b00};
      rem  <= ge ? ACCEL_WIDTH'(shifted - trial) : ACCEL_WIDTH'(shifted);
      root <= {root[ACCEL_WIDTH-2:0], ge};
    end
  end

endmodule
